// File: design/rau_pkg.sv
// Shared constants, operation codes and unit control types of the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int KIND_W           = 4;
  localparam int STATUS_W         = 2;
  localparam int RES_NUM_W        = 32;
  localparam int RES_DEN_W        = 31;
  localparam int OUT_DATA_W       = RES_NUM_W + RES_DEN_W + 1;

  localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
  localparam logic [KIND_W-1:0] KIND_EQ  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_NE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LT  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GT  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_LE  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_GE  = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DENZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

  // Control beat from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic short_op;
  } div_ctl_t;

  // Control beat from the sequencer to the gcd unit.
  typedef struct packed {
    logic start;
  } gcd_ctl_t;

endpackage

// File: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and result register.
//
// One operation on two fractions is taken per input beat on the s_ channel: the
// operation code travels in s_tuser, the four operand parts in s_tdata. Each
// operand is reduced to canonical form (sign in the numerator, positive
// denominator, divided by the gcd), then the unit adds, subtracts, multiplies,
// divides or compares, and the reduced result leaves as one beat on the m_
// channel with the status code in m_tuser.
// The unit works on one beat at a time; s_tready is high only while idle.
// The time a beat takes depends on the values, through the shared binary gcd unit
// (one step per cycle; three runs for arithmetic, two for comparisons) and the
// bit-serial divider (four operand divides, plus two result divides for
// arithmetic). Beats rejected for a zero denominator, a division by zero or an
// unused code skip the gcd and divider runs and go straight to the final state.
// The finished result sits in an output register; while it is still held there
// with m_tready low, the next result waits in the final state and no new beat is taken.
// A synchronous reset returns the sequencer to idle and drops m_tvalid.
module rational_arithmetic_unit #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_num, a_den, b_num, b_den, each OPERAND_BITS wide, zero padded to bytes
  input  logic [((4*OPERAND_BITS+7)/8)*8-1:0]    s_tdata,
  // kind
  input  logic [rau_pkg::KIND_W-1:0]             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // res_num [31:0], res_den [62:32], truth [63]
  output logic [rau_pkg::OUT_DATA_W-1:0]         m_tdata,
  // status
  output logic [rau_pkg::STATUS_W-1:0]           m_tuser
);

  localparam int OB = OPERAND_BITS;
  localparam int PW = 2 * OB;
  localparam int W  = PW + 1;
  localparam int RW = (W > rau_pkg::RES_NUM_W) ? W : rau_pkg::RES_NUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GA   = 4'd1;
  localparam logic [3:0] S_DAN  = 4'd2;
  localparam logic [3:0] S_DAD  = 4'd3;
  localparam logic [3:0] S_GB   = 4'd4;
  localparam logic [3:0] S_DBN  = 4'd5;
  localparam logic [3:0] S_DBD  = 4'd6;
  localparam logic [3:0] S_MP   = 4'd7;
  localparam logic [3:0] S_MQ   = 4'd8;
  localparam logic [3:0] S_MD   = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_GT   = 4'd11;
  localparam logic [3:0] S_DTN  = 4'd12;
  localparam logic [3:0] S_DTD  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  function automatic logic [OB-1:0] mag_of(input logic [OB-1:0] val);
    mag_of = val[OB-1] ? (~val + {{(OB-1){1'b0}}, 1'b1}) : val;
  endfunction

  logic [3:0] state;
  logic [3:0] state_next;
  logic       go;
  logic       accept;

  logic [rau_pkg::KIND_W-1:0]   kind;
  logic [rau_pkg::STATUS_W-1:0] status;
  logic                         truth;

  // Operand magnitudes; overwritten in place by their reduced values.
  logic [OB-1:0] a_nm;
  logic [OB-1:0] a_dm;
  logic [OB-1:0] b_nm;
  logic [OB-1:0] b_dm;
  logic          a_neg;
  logic          b_neg;

  logic [PW-1:0] prod;
  logic [PW-1:0] p;
  logic [PW-1:0] q;
  logic [OB-1:0] mul_x;
  logic [OB-1:0] mul_y;

  // Unreduced result, then reduced in place.
  logic [W-1:0] t_mag;
  logic [W-1:0] t_den;
  logic         t_neg;

  logic [OB-1:0] in_a_num;
  logic [OB-1:0] in_a_den;
  logic [OB-1:0] in_b_num;
  logic [OB-1:0] in_b_den;
  logic          den_zero;
  logic          div_zero;
  logic          bad_kind;

  rau_pkg::gcd_ctl_t gcd_ctl;
  rau_pkg::div_ctl_t div_ctl;
  logic [W-1:0]      gcd_x;
  logic [W-1:0]      gcd_y;
  logic              gcd_done;
  logic [W-1:0]      gcd_g;
  logic [W-1:0]      div_num;
  logic              div_done;
  logic [W-1:0]      div_quo;

  logic [W-1:0] pe;
  logic [W-1:0] qe;
  logic         p_neg;
  logic         q_neg;
  logic         c_eq;
  logic         c_lt;
  logic         cmp_truth;
  logic [W-1:0] sum_mag;
  logic         sum_neg;

  logic [RW-1:0] num_ext;
  logic [RW-1:0] num_signed;
  logic [RW-1:0] den_ext;
  logic          out_load;

  assign in_a_num = s_tdata[OB-1:0];
  assign in_a_den = s_tdata[2*OB-1:OB];
  assign in_b_num = s_tdata[3*OB-1:2*OB];
  assign in_b_den = s_tdata[4*OB-1:3*OB];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign den_zero = (in_a_den == '0) || (in_b_den == '0);
  assign div_zero = (s_tuser == rau_pkg::KIND_DIV) && (in_b_num == '0);
  assign bad_kind = (s_tuser > rau_pkg::KIND_GE);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (den_zero || div_zero || bad_kind) ? S_FIN : S_GA;
        end
      end
      S_GA:  if (!go && gcd_done) state_next = S_DAN;
      S_DAN: if (!go && div_done) state_next = S_DAD;
      S_DAD: if (!go && div_done) state_next = S_GB;
      S_GB:  if (!go && gcd_done) state_next = S_DBN;
      S_DBN: if (!go && div_done) state_next = S_DBD;
      S_DBD: if (!go && div_done) state_next = S_MP;
      S_MP:  state_next = S_MQ;
      S_MQ:  state_next = S_MD;
      S_MD:  state_next = S_SUM;
      S_SUM: state_next = (kind >= rau_pkg::KIND_EQ) ? S_FIN : S_GT;
      S_GT:  if (!go && gcd_done) state_next = S_DTN;
      S_DTN: if (!go && div_done) state_next = S_DTD;
      S_DTD: if (!go && div_done) state_next = S_FIN;
      S_FIN: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The shared units are launched in the first cycle of each state that uses them.
  always_comb begin
    gcd_ctl.start    = go && (state == S_GA || state == S_GB || state == S_GT);
    div_ctl.start    = go && (state == S_DAN || state == S_DAD || state == S_DBN ||
                              state == S_DBD || state == S_DTN || state == S_DTD);
    div_ctl.short_op = !(state == S_DTN || state == S_DTD);
  end

  always_comb begin
    unique case (state)
      S_GB: begin
        gcd_x = W'(b_nm);
        gcd_y = W'(b_dm);
      end
      S_GT: begin
        gcd_x = t_mag;
        gcd_y = t_den;
      end
      default: begin
        gcd_x = W'(a_nm);
        gcd_y = W'(a_dm);
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_DAD:   div_num = W'(a_dm);
      S_DBN:   div_num = W'(b_nm);
      S_DBD:   div_num = W'(b_dm);
      S_DTN:   div_num = t_mag;
      S_DTD:   div_num = t_den;
      default: div_num = W'(a_nm);
    endcase
  end

  rau_gcd #(
    .WIDTH (W)
  ) u_gcd (
    .clk  (clk),
    .rst  (rst),
    .ctl  (gcd_ctl),
    .x    (gcd_x),
    .y    (gcd_y),
    .done (gcd_done),
    .g    (gcd_g)
  );

  rau_div #(
    .WIDTH      (W),
    .SHORT_BITS (OB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_num),
    .divisor  (gcd_g),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Multiplier operands: P = na*db (na*nb for mul), Q = nb*da, D = da*db (da*nb for div).
  always_comb begin
    unique case (state)
      S_MQ: begin
        mul_x = b_nm;
        mul_y = a_dm;
      end
      S_MD: begin
        mul_x = a_dm;
        mul_y = (kind == rau_pkg::KIND_DIV) ? b_nm : b_dm;
      end
      default: begin
        mul_x = a_nm;
        mul_y = (kind == rau_pkg::KIND_MUL) ? b_nm : b_dm;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_x) * PW'(mul_y);
  end

  // Signed combination of the two cross products, and the comparison of them.
  assign pe    = W'(p);
  assign qe    = W'(q);
  assign p_neg = (p != '0) &&
                 (a_neg ^ (b_neg && (kind == rau_pkg::KIND_MUL || kind == rau_pkg::KIND_DIV)));
  assign q_neg = (q != '0) && (b_neg ^ (kind == rau_pkg::KIND_SUB));
  assign c_eq  = ((p == '0) && (q == '0)) || ((p_neg == q_neg) && (p == q));
  assign c_lt  = !c_eq && ((p_neg != q_neg) ? p_neg : ((p > q) ? p_neg : !p_neg));

  always_comb begin
    unique case (kind)
      rau_pkg::KIND_EQ: cmp_truth = c_eq;
      rau_pkg::KIND_NE: cmp_truth = !c_eq;
      rau_pkg::KIND_LT: cmp_truth = c_lt;
      rau_pkg::KIND_GT: cmp_truth = !c_eq && !c_lt;
      rau_pkg::KIND_LE: cmp_truth = c_eq || c_lt;
      rau_pkg::KIND_GE: cmp_truth = !c_lt;
      default:          cmp_truth = 1'b0;
    endcase
  end

  always_comb begin
    if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB) begin
      priority if (p_neg == q_neg) begin
        sum_mag = pe + qe;
        sum_neg = p_neg;
      end else if (pe >= qe) begin
        sum_mag = pe - qe;
        sum_neg = p_neg;
      end else begin
        sum_mag = qe - pe;
        sum_neg = q_neg;
      end
    end else begin
      sum_mag = pe;
      sum_neg = p_neg;
    end
  end

  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      go       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= (state_next != state);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          kind  <= s_tuser;
          a_nm  <= mag_of(in_a_num);
          a_dm  <= mag_of(in_a_den);
          b_nm  <= mag_of(in_b_num);
          b_dm  <= mag_of(in_b_den);
          a_neg <= (in_a_num != '0) && (in_a_num[OB-1] ^ in_a_den[OB-1]);
          b_neg <= (in_b_num != '0) && (in_b_num[OB-1] ^ in_b_den[OB-1]);
          t_mag <= '0;
          t_den <= W'(1);
          t_neg <= 1'b0;
          truth <= 1'b0;
          if (den_zero) begin
            status <= rau_pkg::ST_DENZERO;
          end else if (div_zero) begin
            status <= rau_pkg::ST_DIVZERO;
          end else begin
            status <= rau_pkg::ST_OK;
          end
        end
      end
      S_DAN: if (!go && div_done) a_nm <= div_quo[OB-1:0];
      S_DAD: if (!go && div_done) a_dm <= div_quo[OB-1:0];
      S_DBN: if (!go && div_done) b_nm <= div_quo[OB-1:0];
      S_DBD: if (!go && div_done) b_dm <= div_quo[OB-1:0];
      S_MQ:  p <= prod;
      S_MD:  q <= prod;
      S_SUM: begin
        if (kind >= rau_pkg::KIND_EQ) begin
          truth <= cmp_truth;
        end else begin
          t_mag <= sum_mag;
          t_neg <= sum_neg;
          t_den <= W'(prod);
        end
      end
      S_DTN: if (!go && div_done) t_mag <= div_quo;
      S_DTD: if (!go && div_done) t_den <= div_quo;
      default: begin
      end
    endcase
  end

  // Results wider than the output fields wrap.
  assign num_ext    = RW'(t_mag);
  assign num_signed = t_neg ? -num_ext : num_ext;
  assign den_ext    = RW'(t_den);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {truth, den_ext[rau_pkg::RES_DEN_W-1:0], num_signed[rau_pkg::RES_NUM_W-1:0]};
      m_tuser <= status;
    end
  end

endmodule

// File: design/rau_gcd.sv
// Binary gcd unit: one compare, subtract and shift step per cycle.
module rau_gcd #(
  parameter int WIDTH = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::gcd_ctl_t   ctl,
  input  logic [WIDTH-1:0]    x,
  input  logic [WIDTH-1:0]    y,
  output logic                done,
  output logic [WIDTH-1:0]    g
);

  localparam int KW = $clog2(WIDTH + 1);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_RUN   = 2'd1;
  localparam logic [1:0] G_SHIFT = 2'd2;

  logic [1:0]       state;
  logic [WIDTH-1:0] u;
  logic [WIDTH-1:0] v;
  logic [KW-1:0]    k;
  logic [WIDTH-1:0] u_minus_v;
  logic [WIDTH-1:0] v_minus_u;

  assign u_minus_v = u - v;
  assign v_minus_u = v - u;

  // The common power of two is stripped first and restored one shift a cycle at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        u     <= x;
        v     <= y;
        k     <= '0;
        state <= G_RUN;
      end else begin
        unique case (state)
          G_RUN: begin
            priority if (u == '0 || v == '0) begin
              g     <= ((u | v) == '0) ? WIDTH'(1) : (u | v);
              state <= G_SHIFT;
            end else if (!u[0] && !v[0]) begin
              u <= u >> 1;
              v <= v >> 1;
              k <= k + KW'(1);
            end else if (!u[0]) begin
              u <= u >> 1;
            end else if (!v[0]) begin
              v <= v >> 1;
            end else if (u >= v) begin
              u <= u_minus_v >> 1;
            end else begin
              v <= v_minus_u >> 1;
            end
          end
          G_SHIFT: begin
            if (k == '0) begin
              done  <= 1'b1;
              state <= G_IDLE;
            end else begin
              g <= g << 1;
              k <= k - KW'(1);
            end
          end
          default: state <= G_IDLE;
        endcase
      end
    end
  end

endmodule

// File: design/rau_div.sv
// Restoring divider that produces one quotient bit per cycle.
module rau_div #(
  parameter int WIDTH      = 33,
  parameter int SHORT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::div_ctl_t   ctl,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output logic                done,
  output logic [WIDTH-1:0]    quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] rem_next;

  assign shifted  = {rem, quo[WIDTH-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign fits     = !diff[WIDTH];
  assign rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.short_op ? CW'(SHORT_BITS) : CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A short dividend is moved to the top so only its own bits are stepped through.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= ctl.short_op ? (dividend << (WIDTH - SHORT_BITS)) : dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[WIDTH-2:0], fits};
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the rational arithmetic unit with a built-in fraction predictor.
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  localparam int OPB = OPERAND_BITS_DEF;
  localparam int IN_W = ((4 * OPB + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1225;
  localparam int QUIET_ITEMS = 150;
  localparam int PHASE_ITEMS = 100;
  // A drain of this length after the last expected result leaves room for any
  // stray result beat to show up.
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int MAX_REPORTS = 40;

  // Codes outside the defined operations; the unit must answer them with 0/1.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0]        den;
    logic                        truth;
    logic [STATUS_W-1:0]         status;
  } fraction_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OPB-1:0]    a_num;
    logic [OPB-1:0]    a_den;
    logic [OPB-1:0]    b_num;
    logic [OPB-1:0]    b_den;
    logic              fixed;
    fraction_t         want;
  } op_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  fraction_t fraction_q[$];
  op_case_t directed_cases[$];
  int error_count = 0;
  int result_count = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  bit idling_on = 1'b1;

  rational_arithmetic_unit #(.OPERAND_BITS(OPB)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Euclid on non-negative values.
  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (x != 0) begin
      t = y % x;
      y = x;
      x = t;
    end
    return y;
  endfunction

  // Canonical form: sign in the numerator, positive denominator, divided by the gcd.
  function automatic void reduce_fraction(input longint n, input longint d,
                                          output longint cn, output longint cd);
    longint nm, dm, g;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    g = gcd_of(nm, dm);
    if (g == 0) g = 1;
    cn = ((n < 0) != (d < 0)) ? -(nm / g) : nm / g;
    cd = dm / g;
  endfunction

  function automatic fraction_t predict_fraction(logic [KIND_W-1:0] kind,
                                                 logic [OPB-1:0] an_r, logic [OPB-1:0] ad_r,
                                                 logic [OPB-1:0] bn_r, logic [OPB-1:0] bd_r);
    fraction_t r;
    longint na, da, nb, db, tn, td, lhs, rhs, g;
    r.num = '0;
    r.den = RES_DEN_W'(1);
    r.truth = 1'b0;
    r.status = ST_OK;
    if ($signed(ad_r) == 0 || $signed(bd_r) == 0) begin
      r.status = ST_DENZERO;
      return r;
    end
    reduce_fraction(longint'($signed(an_r)), longint'($signed(ad_r)), na, da);
    reduce_fraction(longint'($signed(bn_r)), longint'($signed(bd_r)), nb, db);
    if (kind <= KIND_DIV) begin
      td = da * db;
      case (kind)
        KIND_ADD: tn = na * db + nb * da;
        KIND_SUB: tn = na * db - nb * da;
        KIND_MUL: tn = na * nb;
        default: begin
          if (nb == 0) begin
            r.status = ST_DIVZERO;
            return r;
          end
          // Dividing by a negative fraction moves its sign onto the numerator.
          tn = (nb < 0) ? -(na * db) : na * db;
          td = (nb < 0) ? da * -nb : da * nb;
        end
      endcase
      g = gcd_of((tn < 0) ? -tn : tn, td);
      if (g == 0) g = 1;
      r.num = RES_NUM_W'(tn / g);
      r.den = RES_DEN_W'(td / g);
    end else if (kind <= KIND_GE) begin
      lhs = na * db;
      rhs = nb * da;
      case (kind)
        KIND_EQ: r.truth = (lhs == rhs);
        KIND_NE: r.truth = (lhs != rhs);
        KIND_LT: r.truth = (lhs < rhs);
        KIND_GT: r.truth = (lhs > rhs);
        KIND_LE: r.truth = (lhs <= rhs);
        default: r.truth = (lhs >= rhs);
      endcase
    end
    return r;
  endfunction

  function automatic op_case_t pred_row(logic [KIND_W-1:0] kind, int an, int ad, int bn, int bd);
    op_case_t c;
    c.kind = kind;
    c.a_num = OPB'(an);
    c.a_den = OPB'(ad);
    c.b_num = OPB'(bn);
    c.b_den = OPB'(bd);
    c.fixed = 1'b0;
    c.want = '0;
    return c;
  endfunction

  function automatic op_case_t fixed_row(logic [KIND_W-1:0] kind, int an, int ad, int bn, int bd,
                                         longint num, longint den, logic truth,
                                         logic [STATUS_W-1:0] status);
    op_case_t c;
    c = pred_row(kind, an, ad, bn, bd);
    c.fixed = 1'b1;
    c.want.num = RES_NUM_W'(num);
    c.want.den = RES_DEN_W'(den);
    c.want.truth = truth;
    c.want.status = status;
    return c;
  endfunction

  // Operand part with a mix of small values, full-range values, extremes and
  // values with many trailing zeros so that the gcd has work to do.
  function automatic int pick_part();
    int extremes[6] = '{-32768, -32767, -1, 0, 1, 32767};
    int v;
    case ($urandom_range(0, 7))
      0, 1: v = int'($urandom_range(0, 40)) - 20;
      2, 3, 7: v = int'($urandom_range(0, 65535)) - 32768;
      4: v = extremes[$urandom_range(0, 5)];
      5: begin
        v = int'($urandom_range(1, 15)) << $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 400)) - 200;
    endcase
    return v;
  endfunction

  // A zero denominator only rejects the beat, so it is let through rarely.
  function automatic int pick_den();
    int v;
    v = pick_part();
    if (v == 0 && $urandom_range(0, 24) != 0) v = int'($urandom_range(1, 9));
    return v;
  endfunction

  function automatic op_case_t random_case();
    op_case_t c;
    int an, ad, k;
    logic [KIND_W-1:0] kind;
    if ($urandom_range(0, 19) == 0) kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    else kind = KIND_W'($urandom_range(KIND_ADD, KIND_GE));
    if ($urandom_range(0, 5) == 0) begin
      // Equal values written differently, so that comparisons hit equality and
      // subtraction gives zero.
      an = int'($urandom_range(0, 4000)) - 2000;
      ad = int'($urandom_range(1, 4000)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
      k = int'($urandom_range(1, 7)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
      c = pred_row(kind, an, ad, an * k, ad * k);
    end else begin
      c = pred_row(kind, pick_part(), pick_den(),
                   ($urandom_range(0, 19) == 0) ? 0 : pick_part(), pick_den());
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR result beat %0d: %s is %0d, expected %0d", result_count, what, got, want);
  endtask

  // Drives one operation beat, holds it until accepted, then records what the
  // unit must return for it. A random gap may follow while idling is on.
  task automatic offer_beat(op_case_t c);
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({c.b_den, c.b_num, c.a_den, c.a_num});
    s_tuser <= c.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c.fixed) fraction_q.push_back(c.want);
    else fraction_q.push_back(predict_fraction(c.kind, c.a_num, c.a_den, c.b_num, c.b_den));
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    op_case_t c;
    @(posedge clk);
    while (rst) @(posedge clk);

    directed_cases.push_back(pred_row(KIND_ADD, 1, 2, 1, 3));
    directed_cases.push_back(fixed_row(KIND_ADD, 1, 2, 1, 2, 1, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_SUB, 1, 2, 1, 2, 0, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_ADD, -32768, 1, -32768, 1, -65536, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_SUB, 32767, 1, -32768, 1, 65535, 1, 1'b0, ST_OK));
    directed_cases.push_back(pred_row(KIND_ADD, 32767, -32768, -32768, 32767));
    directed_cases.push_back(pred_row(KIND_SUB, -32768, 32767, 32767, -32768));
    directed_cases.push_back(fixed_row(KIND_MUL, -32768, 1, -32768, 1, 1073741824, 1, 1'b0,
                                       ST_OK));
    directed_cases.push_back(fixed_row(KIND_MUL, 32767, 32767, -1, -1, 1, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_MUL, 0, -7, 5, 3, 0, 1, 1'b0, ST_OK));
    directed_cases.push_back(pred_row(KIND_MUL, -32768, -1, 32767, -1));
    // Largest possible result denominator.
    directed_cases.push_back(fixed_row(KIND_DIV, 1, -32768, -32768, 1, 1, 1073741824, 1'b0,
                                       ST_OK));
    directed_cases.push_back(pred_row(KIND_DIV, -32768, 32767, 32767, -32768));
    directed_cases.push_back(fixed_row(KIND_DIV, 6, 4, 0, 9, 0, 1, 1'b0, ST_DIVZERO));
    // A zero operand denominator wins over a division by zero.
    directed_cases.push_back(fixed_row(KIND_DIV, 3, 0, 0, 5, 0, 1, 1'b0, ST_DENZERO));
    directed_cases.push_back(fixed_row(KIND_ADD, 1, 2, 1, 0, 0, 1, 1'b0, ST_DENZERO));
    directed_cases.push_back(fixed_row(KIND_EQ, 0, 0, 0, 0, 0, 1, 1'b0, ST_DENZERO));
    directed_cases.push_back(fixed_row(KIND_EQ, 2, 4, -3, -6, 0, 1, 1'b1, ST_OK));
    directed_cases.push_back(fixed_row(KIND_NE, 2, 4, 1, 3, 0, 1, 1'b1, ST_OK));
    directed_cases.push_back(fixed_row(KIND_LT, -1, 2, 1, -3, 0, 1, 1'b1, ST_OK));
    directed_cases.push_back(fixed_row(KIND_GT, -1, 2, 1, -3, 0, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_LE, 5, 10, 1, 2, 0, 1, 1'b1, ST_OK));
    directed_cases.push_back(fixed_row(KIND_GE, -32768, 1, 32767, 1, 0, 1, 1'b0, ST_OK));
    // Zeros of opposite sign compare as equal.
    directed_cases.push_back(fixed_row(KIND_LT, 0, -5, 0, 3, 0, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_UNUSED_LO, 1, 2, 1, 3, 0, 1, 1'b0, ST_OK));
    directed_cases.push_back(fixed_row(KIND_UNUSED_HI, -32768, -32768, 32767, 32767, 0, 1, 1'b0,
                                       ST_OK));

    foreach (directed_cases[i]) offer_beat(directed_cases[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Idling comes and goes by phase, and stops for the closing stretch.
      if (i >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
      else if (i % PHASE_ITEMS == 0) idling_on = ($urandom_range(0, 3) != 0);
      c = random_case();
      offer_beat(c);
    end
    s_tvalid <= 1'b0;

    while (fraction_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver side: random stall bursts on m_tready while idling is on.
  always @(posedge clk) begin
    if (idling_on && stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Each result beat is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    fraction_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (fraction_q.size() == 0) begin
        report_mismatch("unexpected beat, res_num", longint'($signed(m_tdata[RES_NUM_W-1:0])), 0);
      end else begin
        want = fraction_q.pop_front();
        if (m_tdata[RES_NUM_W-1:0] != want.num)
          report_mismatch("res_num", longint'($signed(m_tdata[RES_NUM_W-1:0])),
                          longint'(want.num));
        if (m_tdata[RES_NUM_W +: RES_DEN_W] != want.den)
          report_mismatch("res_den", longint'(m_tdata[RES_NUM_W +: RES_DEN_W]),
                          longint'(want.den));
        if (m_tdata[OUT_DATA_W-1] != want.truth)
          report_mismatch("truth", longint'(m_tdata[OUT_DATA_W-1]), longint'(want.truth));
        if (m_tuser != want.status)
          report_mismatch("status", longint'(m_tuser), longint'(want.status));
      end
      result_count++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
